[hw/rtl/svc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constant tables for the stereo channel vocoder.
// No dependencies; every other file but svc_ram uses it by scoped names.
package svc_pkg;

  // Sample word: Q1.23, coefficient word: Q2.22
  localparam int SW    = 24;
  localparam int SFRAC = SW - 1;
  localparam int CFRAC = SW - 2;

  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_COUNT   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_TYPE = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIX_LEVEL    = 4'd3;

  localparam logic [1:0] CAR_NOISE  = 2'd0;
  localparam logic [1:0] CAR_SAW    = 2'd1;
  localparam logic [1:0] CAR_SQUARE = 2'd2;

  localparam int NUM_SLOTS = 5;
  localparam logic [2:0] SLOT_B0 = 3'd0;
  localparam logic [2:0] SLOT_B1 = 3'd1;
  localparam logic [2:0] SLOT_B2 = 3'd2;
  localparam logic [2:0] SLOT_A1 = 3'd3;
  localparam logic [2:0] SLOT_A2 = 3'd4;

  localparam logic [2:0] LANE_L = 3'd0;
  localparam logic [2:0] LANE_R = 3'd1;
  localparam logic [2:0] LANE_C = 3'd2;

  localparam logic [31:0] LFSR_SEED  = 32'hACE1ACE1;
  localparam logic [31:0] LFSR_TAPS  = 32'h80200003;
  localparam logic [23:0] PHASE_HALF = 24'h800000;

  localparam logic [16:0] RELEASE_KEEP = 17'd60293;
  localparam logic [16:0] RELEASE_TAKE = 17'd5243;

  localparam int TANH_LAST = 16;

  // 1/sqrt(bands), Q0.16, indexed by band count
  localparam logic [15:0] NORM_TABLE [0:64] = '{
    16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'd29309, 16'd26755, 16'd24770,
    16'd23170, 16'd21845, 16'd20724, 16'd19760, 16'd18919, 16'd18177, 16'd17515, 16'd16921,
    16'd16384, 16'd15895, 16'd15447, 16'd15035, 16'd14654, 16'd14301, 16'd13972, 16'd13665,
    16'd13377, 16'd13107, 16'd12853, 16'd12612, 16'd12385, 16'd12170, 16'd11965, 16'd11771,
    16'd11585, 16'd11408, 16'd11239, 16'd11078, 16'd10923, 16'd10774, 16'd10631, 16'd10494,
    16'd10362, 16'd10235, 16'd10112, 16'd9994,  16'd9880,  16'd9770,  16'd9663,  16'd9559,
    16'd9459,  16'd9362,  16'd9268,  16'd9177,  16'd9088,  16'd9002,  16'd8918,  16'd8837,
    16'd8758,  16'd8680,  16'd8605,  16'd8532,  16'd8461,  16'd8391,  16'd8323,  16'd8257,
    16'd8192
  };

  // tanh at steps of 0.25 over 0..4, Q0.16
  localparam logic [15:0] TANH_TABLE [0:16] = '{
    16'd0,     16'd16051, 16'd30285, 16'd41625, 16'd49912, 16'd55593, 16'd59320, 16'd61694,
    16'd63179, 16'd64096, 16'd64659, 16'd65003, 16'd65212, 16'd65339, 16'd65417, 16'd65464,
    16'd65492
  };

  typedef struct packed {
    logic signed [SW-1:0] x1;
    logic signed [SW-1:0] x2;
    logic signed [SW-1:0] y1;
    logic signed [SW-1:0] y2;
  } hist_t;

  // One state memory word per band: three filter histories and two envelopes
  typedef struct packed {
    hist_t [2:0]  hist;
    logic [SW-1:0] env_l;
    logic [SW-1:0] env_r;
  } band_state_t;

endpackage

[hw/rtl/svc_if.sv]
`timescale 1ns / 1ps
// Valid/ready channels of the stereo channel vocoder: input, result, config.
// Depends on svc_pkg for the sample width.
interface svc_in_if;
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic signed [svc_pkg::SW-1:0]  left_in;
  logic signed [svc_pkg::SW-1:0]  right_in;
  logic [3:0]                     coef_band;
  logic [2:0]                     coef_slot;
  logic signed [svc_pkg::SW-1:0]  coef_value;
  modport source (output valid, op, left_in, right_in, coef_band, coef_slot, coef_value,
                  input ready);
  modport sink (input valid, op, left_in, right_in, coef_band, coef_slot, coef_value,
                output ready);
endinterface

interface svc_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [svc_pkg::SW-1:0]  left_out;
  logic signed [svc_pkg::SW-1:0]  right_out;
  modport source (output valid, left_out, right_out, input ready);
  modport sink (input valid, left_out, right_out, output ready);
endinterface

interface svc_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [svc_pkg::CFG_IDX_W-1:0]        index;
  logic [svc_pkg::SW-1:0]               data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/svc_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module svc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 80,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/stereo_channel_vocoder.sv]
`timescale 1ns / 1ps
// Stereo channel vocoder top level: filter bank sequencer, envelopes, mix.
// Depends on svc_pkg, the channel interfaces in svc_if and svc_ram.

// A sample word (op 0) is worked through band by band over N bands, N being
// band_count clamped to 4..MAX_BAND_COUNT; no new word is accepted until its
// result is loaded. Each band is a read of its state word and coefficients, five
// multiply-accumulate steps of three biquad lanes (left, right, carrier) that
// share the coefficient read port one slot a cycle, then rounding, envelope
// update and write-back; normalization, soft-clip and crossfade follow the last band.
// A coefficient write word (op 1) is taken while idle and gives no result. The
// result sits in an output register, so a stalled sink only holds the block
// at the last mix step. Band state (histories, envelopes) reads as zero until
// a band is first processed after reset, through one valid bit per band; no
// clearing pass is needed. Coefficients must be written before use. Config
// writes are taken in any cycle but belong to idle periods.
module stereo_channel_vocoder #(
  parameter int MAX_BAND_COUNT = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  svc_in_if.sink    in_i,
  svc_out_if.source out_o,
  svc_cfg_if.sink   cfg_i
);

  localparam int SW    = svc_pkg::SW;
  localparam int SFRAC = svc_pkg::SFRAC;
  localparam int CFRAC = svc_pkg::CFRAC;
  localparam int BW    = $clog2(MAX_BAND_COUNT);
  localparam int NW    = $clog2(MAX_BAND_COUNT + 1);
  localparam int CDEP  = MAX_BAND_COUNT * svc_pkg::NUM_SLOTS;
  localparam int CAW   = $clog2(CDEP);
  localparam int AW    = 2 * SW + 3;
  localparam int WW    = SW + 2 + BW;
  localparam int XW    = WW + 1;
  localparam int STW   = $bits(svc_pkg::band_state_t);
  localparam int LANE_IDX_C = int'(svc_pkg::LANE_C);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_MAC  = 4'd2;
  localparam logic [3:0] S_Y    = 4'd3;
  localparam logic [3:0] S_ENV  = 4'd4;
  localparam logic [3:0] S_WET  = 4'd5;
  localparam logic [3:0] S_NORM = 4'd6;
  localparam logic [3:0] S_CLIP = 4'd7;
  localparam logic [3:0] S_MIXA = 4'd8;
  localparam logic [3:0] S_MIXB = 4'd9;

  // Registers
  logic [3:0]            state_q, state_d;
  logic [BW-1:0]         band_q, band_d;
  logic [2:0]            k_q, k_d;
  logic [NW-1:0]         n_q;
  logic [MAX_BAND_COUNT-1:0] band_valid_q;
  logic [4:0]            band_count_q;
  logic [1:0]            carrier_type_q;
  logic [23:0]           phase_step_q;
  logic [15:0]           mix_q;
  logic [23:0]           phase_q;
  logic [31:0]           lfsr_q;
  logic                  out_vld_q;
  logic signed [SW-1:0]  out_l_q, out_r_q;

  logic signed [SW-1:0]  lane_x_q [3];
  logic signed [AW-1:0]  acc_q [3];
  logic signed [SW-1:0]  y_q [3];
  logic [SW-1:0]         env_q [2];
  logic signed [WW-1:0]  wet_q [2];
  logic signed [XW-1:0]  nrm_q [2];
  logic signed [SW-1:0]  clip_q [2];
  logic signed [SW+17:0] mixp_q [2];

  // Handshakes
  logic in_acc, smp_acc, coef_acc, out_load;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign smp_acc     = in_acc && (in_i.op == svc_pkg::OP_SAMPLE);
  assign coef_acc    = in_acc && (in_i.op == svc_pkg::OP_COEF);
  assign cfg_i.ready = 1'b1;
  assign out_load    = (state_q == S_MIXB) && (!out_vld_q || out_o.ready);

  assign out_o.valid     = out_vld_q;
  assign out_o.left_out  = out_l_q;
  assign out_o.right_out = out_r_q;

  // Memories
  logic            coef_we, coef_re, st_we, st_re;
  logic [CAW-1:0]  coef_waddr, coef_raddr, coef_base;
  logic [SW-1:0]   coef_rdata;
  logic [STW-1:0]  st_rdata, st_wdata;

  assign coef_we = coef_acc && (int'(in_i.coef_band) < MAX_BAND_COUNT)
                   && (in_i.coef_slot <= svc_pkg::SLOT_A2);
  assign coef_waddr = CAW'(int'(in_i.coef_band) * svc_pkg::NUM_SLOTS + int'(in_i.coef_slot));
  assign coef_base  = CAW'(int'(band_q) * svc_pkg::NUM_SLOTS);
  // Fetch slot 0 at the band read, then one slot ahead of each MAC step
  assign coef_re    = (state_q == S_RD) || ((state_q == S_MAC) && (k_q < svc_pkg::SLOT_A2));
  assign coef_raddr = (state_q == S_RD) ? coef_base : coef_base + CAW'(k_q) + CAW'(1);
  assign st_re      = (state_q == S_RD);
  assign st_we      = (state_q == S_WET);

  svc_ram #(.WIDTH(SW), .DEPTH(CDEP)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (in_i.coef_value),
    .re_i    (coef_re),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  // Same band is never read while its write-back is pending: the sequence
  // writes at the end of a band and reads the next band afterwards.
  svc_ram #(.WIDTH(STW), .DEPTH(MAX_BAND_COUNT)) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (band_q),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (band_q),
    .rdata_o (st_rdata)
  );

  // A band not yet processed since reset reads as all-zero state
  svc_pkg::band_state_t st, st_new;
  assign st       = band_valid_q[band_q] ? svc_pkg::band_state_t'(st_rdata) : '0;
  assign st_wdata = STW'(st_new);

  // Carrier source, advanced once per sample word
  logic [23:0]          phase_next;
  logic [31:0]          lfsr_next;
  logic signed [SW-1:0] car;
  logic                 use_phase;

  assign phase_next = phase_q + phase_step_q;
  assign lfsr_next  = (lfsr_q >> 1) ^ (lfsr_q[0] ? svc_pkg::LFSR_TAPS : 32'd0);
  assign use_phase  = (carrier_type_q == svc_pkg::CAR_SAW)
                      || (carrier_type_q == svc_pkg::CAR_SQUARE);

  always_comb begin
    unique case (carrier_type_q)
      svc_pkg::CAR_SAW:    car = {~phase_next[23], phase_next[22:0]};
      svc_pkg::CAR_SQUARE: car = (phase_next < svc_pkg::PHASE_HALF) ? svc_pkg::SMAX
                                                                   : svc_pkg::SMIN;
      default:             car = lfsr_next[31 -: SW];
    endcase
  end

  // Clamped band count
  logic [NW-1:0] n_clamp;
  always_comb begin
    priority if (band_count_q < 5'd4) begin
      n_clamp = NW'(4);
    end else if (int'(band_count_q) > MAX_BAND_COUNT) begin
      n_clamp = NW'(MAX_BAND_COUNT);
    end else begin
      n_clamp = NW'(band_count_q);
    end
  end

  function automatic logic signed [SW-1:0] sat_acc(input logic signed [AW-1:0] v);
    if (v > AW'(svc_pkg::SMAX)) return svc_pkg::SMAX;
    if (v < AW'(svc_pkg::SMIN)) return svc_pkg::SMIN;
    return v[SW-1:0];
  endfunction

  // Per-lane datapath
  logic signed [SW-1:0]   opnd [3];
  logic signed [2*SW-1:0] prod [3];
  logic signed [AW-1:0]   acc_base [3];
  logic signed [AW-1:0]   mac_sum [3];
  logic signed [AW-1:0]   rnd [3];
  logic signed [SW-1:0]   y_new [3];
  logic [SW-1:0]          mag [2];
  logic [SW-1:0]          env_old [2];
  logic [SW+18:0]         rel_sum [2];
  logic [SW-1:0]          env_new [2];
  logic signed [2*SW:0]   wprod [2];
  logic signed [2*SW:0]   wterm [2];
  logic signed [WW+16:0]  nprod [2];
  logic [XW-1:0]          clip_a [2];
  logic [XW-1:0]          clip_idx [2];
  logic [15:0]            t_lo [2], t_hi [2], t_y [2];
  logic [SFRAC+15:0]      t_int [2];
  logic [SFRAC+16:0]      t_scaled [2];
  logic signed [SW-1:0]   clip_mag [2], clip_new [2];
  logic signed [SW+19:0]  mix_sum [2];
  logic signed [SW+19:0]  mix_sh [2];
  logic signed [SW-1:0]   mix_out [2];
  logic [16:0]            dry_w;

  assign env_old[0] = st.env_l;
  assign env_old[1] = st.env_r;
  assign dry_w      = 17'd65536 - 17'(mix_q);

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      unique case (k_q)
        svc_pkg::SLOT_B0: opnd[l] = lane_x_q[l];
        svc_pkg::SLOT_B1: opnd[l] = st.hist[l].x1;
        svc_pkg::SLOT_B2: opnd[l] = st.hist[l].x2;
        svc_pkg::SLOT_A1: opnd[l] = st.hist[l].y1;
        default:          opnd[l] = st.hist[l].y2;
      endcase
      prod[l]     = $signed(coef_rdata) * opnd[l];
      acc_base[l] = (k_q == svc_pkg::SLOT_B0) ? '0 : acc_q[l];
      mac_sum[l]  = (k_q >= svc_pkg::SLOT_A1) ? acc_base[l] - AW'(prod[l])
                                              : acc_base[l] + AW'(prod[l]);
      // round half up to sample format, saturate
      rnd[l]   = (acc_q[l] + (AW'(1) <<< (CFRAC - 1))) >>> CFRAC;
      y_new[l] = sat_acc(rnd[l]);
    end

    for (int s = 0; s < 2; s++) begin
      // envelope: instant attack, release 0.92
      if (y_q[s] == svc_pkg::SMIN) begin
        mag[s] = svc_pkg::SMAX;
      end else if (y_q[s] < 0) begin
        mag[s] = -y_q[s];
      end else begin
        mag[s] = y_q[s];
      end
      rel_sum[s] = (SW+19)'(svc_pkg::RELEASE_KEEP) * (SW+19)'(env_old[s])
                 + (SW+19)'(svc_pkg::RELEASE_TAKE) * (SW+19)'(mag[s])
                 + (SW+19)'(32768);
      env_new[s] = (mag[s] > env_old[s]) ? mag[s] : rel_sum[s][SW+15:16];

      // carrier band times envelope, rounded to sample format
      wprod[s] = y_q[LANE_IDX_C] * $signed({1'b0, env_q[s]});
      wterm[s] = (wprod[s] + ((2*SW+1)'(1) <<< (SFRAC - 1))) >>> SFRAC;

      nprod[s] = wet_q[s] * $signed({1'b0, svc_pkg::NORM_TABLE[7'(n_q)]});

      // soft clip through the tanh table
      clip_a[s]   = (nrm_q[s] < 0) ? XW'(-nrm_q[s]) : XW'(nrm_q[s]);
      clip_idx[s] = clip_a[s] >> (SFRAC - 2);
      t_lo[s]     = svc_pkg::TANH_TABLE[5'(clip_idx[s][3:0])];
      t_hi[s]     = svc_pkg::TANH_TABLE[5'(clip_idx[s][3:0]) + 5'd1];
      t_int[s]    = (SFRAC+16)'(t_hi[s] - t_lo[s]) * (SFRAC+16)'(clip_a[s][SFRAC-3:0])
                  + ((SFRAC+16)'(1) << (SFRAC - 3));
      if (clip_idx[s] >= XW'(svc_pkg::TANH_LAST)) begin
        t_y[s] = svc_pkg::TANH_TABLE[svc_pkg::TANH_LAST];
      end else begin
        t_y[s] = t_lo[s] + t_int[s][SFRAC+13:SFRAC-2];
      end
      t_scaled[s] = (((SFRAC+17)'(t_y[s]) << SFRAC) + (SFRAC+17)'(32768)) >> 16;
      clip_mag[s] = (t_scaled[s] > (SFRAC+17)'(svc_pkg::SMAX)) ? svc_pkg::SMAX
                                                               : SW'(t_scaled[s]);
      clip_new[s] = (nrm_q[s] < 0) ? -clip_mag[s] : clip_mag[s];

      // dry/wet crossfade, round half up then saturate
      mix_sum[s] = (SW+20)'(mixp_q[s]) + (SW+20)'(clip_q[s] * $signed({1'b0, mix_q}))
                 + (SW+20)'(32768);
      mix_sh[s]  = mix_sum[s] >>> 16;
      if (mix_sh[s] > (SW+20)'(svc_pkg::SMAX)) begin
        mix_out[s] = svc_pkg::SMAX;
      end else if (mix_sh[s] < (SW+20)'(svc_pkg::SMIN)) begin
        mix_out[s] = svc_pkg::SMIN;
      end else begin
        mix_out[s] = mix_sh[s][SW-1:0];
      end
    end
  end

  // Write-back word: shift histories, store envelopes
  always_comb begin
    st_new = st;
    for (int l = 0; l < 3; l++) begin
      st_new.hist[l].x1 = lane_x_q[l];
      st_new.hist[l].x2 = st.hist[l].x1;
      st_new.hist[l].y1 = y_q[l];
      st_new.hist[l].y2 = st.hist[l].y1;
    end
    st_new.env_l = env_q[0];
    st_new.env_r = env_q[1];
  end

  logic last_band;
  assign last_band = (NW'(band_q) + NW'(1)) == n_q;

  // Sequencer
  always_comb begin
    state_d = state_q;
    band_d  = band_q;
    k_d     = k_q;
    unique case (state_q)
      S_IDLE: begin
        if (smp_acc) begin
          state_d = S_RD;
          band_d  = '0;
        end
      end
      S_RD: begin
        state_d = S_MAC;
        k_d     = svc_pkg::SLOT_B0;
      end
      S_MAC: begin
        if (k_q == svc_pkg::SLOT_A2) begin
          state_d = S_Y;
        end else begin
          k_d = k_q + 3'd1;
        end
      end
      S_Y:   state_d = S_ENV;
      S_ENV: state_d = S_WET;
      S_WET: begin
        if (last_band) begin
          state_d = S_NORM;
        end else begin
          state_d = S_RD;
          band_d  = band_q + BW'(1);
        end
      end
      S_NORM: state_d = S_CLIP;
      S_CLIP: state_d = S_MIXA;
      S_MIXA: state_d = S_MIXB;
      S_MIXB: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state and config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      band_q         <= '0;
      k_q            <= '0;
      n_q            <= NW'(MAX_BAND_COUNT);
      band_valid_q   <= '0;
      band_count_q   <= 5'd16;
      carrier_type_q <= svc_pkg::CAR_NOISE;
      phase_step_q   <= 24'd34953;
      mix_q          <= 16'd32768;
      phase_q        <= '0;
      lfsr_q         <= svc_pkg::LFSR_SEED;
      out_vld_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      band_q  <= band_d;
      k_q     <= k_d;
      if (smp_acc) begin
        n_q <= n_clamp;
        if (use_phase) begin
          phase_q <= phase_next;
        end else begin
          lfsr_q <= lfsr_next;
        end
      end
      if (st_we) begin
        band_valid_q[band_q] <= 1'b1;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          svc_pkg::CFG_BAND_COUNT:   band_count_q   <= cfg_i.data[4:0];
          svc_pkg::CFG_CARRIER_TYPE: carrier_type_q <= cfg_i.data[1:0];
          svc_pkg::CFG_PHASE_STEP:   phase_step_q   <= cfg_i.data[23:0];
          svc_pkg::CFG_MIX_LEVEL:    mix_q          <= cfg_i.data[15:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (smp_acc) begin
      lane_x_q[0] <= in_i.left_in;
      lane_x_q[1] <= in_i.right_in;
      lane_x_q[2] <= car;
      wet_q[0]    <= '0;
      wet_q[1]    <= '0;
    end
    for (int l = 0; l < 3; l++) begin
      if (state_q == S_MAC) acc_q[l] <= mac_sum[l];
      if (state_q == S_Y)   y_q[l]   <= y_new[l];
    end
    for (int s = 0; s < 2; s++) begin
      if (state_q == S_ENV)  env_q[s]  <= env_new[s];
      if (state_q == S_WET)  wet_q[s]  <= wet_q[s] + WW'(wterm[s]);
      if (state_q == S_NORM) nrm_q[s]  <= XW'((nprod[s] + (WW+17)'(32768)) >>> 16);
      if (state_q == S_CLIP) clip_q[s] <= clip_new[s];
      if (state_q == S_MIXA) mixp_q[s] <= lane_x_q[s] * $signed({1'b0, dry_w});
    end
    if (out_load) begin
      out_l_q <= mix_out[0];
      out_r_q <= mix_out[1];
    end
  end

`ifndef SYNTHESIS
  // Band counter stays inside the active bank while a sample is in work
  a_band_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (NW'(band_q) < n_q))
    else $error("band counter beyond active band count");

  // A coefficient write completes in its own cycle
  a_coef_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (in_i.op == svc_pkg::OP_COEF)) |=> (state_q == S_IDLE))
    else $error("coefficient write left the idle state");

  // A result appears only out of the final mix step
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == S_MIXB))
    else $error("result raised outside the mix step");

  // Write-back marks the band as holding real state
  a_band_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WET) |=> band_valid_q[$past(band_q)])
    else $error("band state written but not marked valid");

  // MAC step counter never passes the last coefficient slot
  a_mac_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC) |-> (k_q <= svc_pkg::SLOT_A2))
    else $error("MAC step beyond coefficient a2");
`endif

endmodule

[sim/svc_checker.sv]
`timescale 1ns / 1ps
// Vocoder checker: watches the input, config and result channels, predicts every result
// word and compares it field by field. Depends on svc_pkg and the channel interfaces.
module svc_checker (
  input  logic clk_i,
  input  logic rst_ni,
  svc_in_if    in_mon,
  svc_out_if   out_mon,
  svc_cfg_if   cfg_mon,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct {
    logic [svc_pkg::SW-1:0] left;
    logic [svc_pkg::SW-1:0] right;
  } stereo_word_t;

  localparam longint SMAXV = 64'sd8388607;
  localparam longint SMINV = -64'sd8388608;

  stereo_word_t mix_queue[$];

  longint coef_mem [16][5];
  longint hist_mem [3][16][4];
  longint env_mem  [2][16];
  logic [23:0] phase_acc;
  logic [31:0] lfsr;
  logic [4:0]  bands_reg;
  logic [1:0]  car_reg;
  logic [23:0] step_reg;
  logic [15:0] mix_reg;

  function automatic longint rnd_shift(longint acc, int k);
    return (acc + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  function automatic longint clamp24(longint v);
    if (v > SMAXV) return SMAXV;
    if (v < SMINV) return SMINV;
    return v;
  endfunction

  function automatic longint biquad_step(longint x, int lane, int b);
    longint acc, y;
    acc = coef_mem[b][0] * x + coef_mem[b][1] * hist_mem[lane][b][0]
        + coef_mem[b][2] * hist_mem[lane][b][1] - coef_mem[b][3] * hist_mem[lane][b][2]
        - coef_mem[b][4] * hist_mem[lane][b][3];
    y = clamp24(rnd_shift(acc, svc_pkg::CFRAC));
    hist_mem[lane][b][1] = hist_mem[lane][b][0];
    hist_mem[lane][b][0] = x;
    hist_mem[lane][b][3] = hist_mem[lane][b][2];
    hist_mem[lane][b][2] = y;
    return y;
  endfunction

  function automatic longint track_env(longint env, longint a);
    if (a > env) return a;
    return (64'sd60293 * env + 64'sd5243 * a + 64'sd32768) >>> 16;
  endfunction

  function automatic longint next_carrier();
    logic lsb;
    if (car_reg == svc_pkg::CAR_SAW || car_reg == svc_pkg::CAR_SQUARE) begin
      phase_acc = phase_acc + step_reg;
      if (car_reg == svc_pkg::CAR_SQUARE)
        return (phase_acc < svc_pkg::PHASE_HALF) ? SMAXV : SMINV;
      return longint'(phase_acc) - longint'(svc_pkg::PHASE_HALF);
    end
    lsb = lfsr[0];
    lfsr = lfsr >> 1;
    if (lsb) lfsr = lfsr ^ svc_pkg::LFSR_TAPS;
    return longint'($signed(lfsr[31:8]));
  endfunction

  function automatic longint tanh_clip(longint x);
    longint a, idx, y, fr, lo, hi;
    a = (x < 0) ? -x : x;
    idx = a >>> 21;
    if (idx >= svc_pkg::TANH_LAST) begin
      y = svc_pkg::TANH_TABLE[svc_pkg::TANH_LAST];
    end else begin
      fr = a & 64'h1F_FFFF;
      lo = svc_pkg::TANH_TABLE[idx];
      hi = svc_pkg::TANH_TABLE[idx + 1];
      y = lo + (((hi - lo) * fr + 64'sd1048576) >>> 21);
    end
    y = ((y <<< 23) + 64'sd32768) >>> 16;
    if (y > SMAXV) y = SMAXV;
    return (x < 0) ? -y : y;
  endfunction

  function automatic longint crossfade(longint dry, longint wet);
    longint m;
    m = longint'(mix_reg);
    return clamp24((dry * (64'sd65536 - m) + wet * m + 64'sd32768) >>> 16);
  endfunction

  function automatic stereo_word_t vocode(longint dry_l, longint dry_r);
    stereo_word_t w;
    int n;
    longint car, ml, mr, cb, wl, wr, norm, al, ar;
    wl = 0;
    wr = 0;
    n = bands_reg;
    if (n < 4) n = 4;
    if (n > 16) n = 16;
    car = next_carrier();
    for (int b = 0; b < n; b++) begin
      ml = biquad_step(dry_l, 0, b);
      mr = biquad_step(dry_r, 1, b);
      al = clamp24((ml < 0) ? -ml : ml);
      ar = clamp24((mr < 0) ? -mr : mr);
      env_mem[0][b] = track_env(env_mem[0][b], al);
      env_mem[1][b] = track_env(env_mem[1][b], ar);
      cb = biquad_step(car, 2, b);
      wl += rnd_shift(cb * env_mem[0][b], svc_pkg::SFRAC);
      wr += rnd_shift(cb * env_mem[1][b], svc_pkg::SFRAC);
    end
    norm = svc_pkg::NORM_TABLE[n];
    wl = tanh_clip(rnd_shift(wl * norm, 16));
    wr = tanh_clip(rnd_shift(wr * norm, 16));
    w.left  = 24'(crossfade(dry_l, wl));
    w.right = 24'(crossfade(dry_r, wr));
    return w;
  endfunction

  task automatic clear_state();
    foreach (coef_mem[b, s]) coef_mem[b][s] = 0;
    foreach (hist_mem[l, b, k]) hist_mem[l][b][k] = 0;
    foreach (env_mem[l, b]) env_mem[l][b] = 0;
    phase_acc = '0;
    lfsr      = svc_pkg::LFSR_SEED;
    bands_reg = 5'd16;
    car_reg   = svc_pkg::CAR_NOISE;
    step_reg  = 24'd34953;
    mix_reg   = 16'd32768;
    mix_queue.delete();
  endtask

  assign pending_o = mix_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    stereo_word_t got, want;
    if (!rst_ni) begin
      clear_state();
      fail_count_o <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          svc_pkg::CFG_BAND_COUNT:   bands_reg = cfg_mon.data[4:0];
          svc_pkg::CFG_CARRIER_TYPE: car_reg   = cfg_mon.data[1:0];
          svc_pkg::CFG_PHASE_STEP:   step_reg  = cfg_mon.data[23:0];
          svc_pkg::CFG_MIX_LEVEL:    mix_reg   = cfg_mon.data[15:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.op == svc_pkg::OP_COEF) begin
          if (in_mon.coef_slot <= svc_pkg::SLOT_A2)
            coef_mem[in_mon.coef_band][in_mon.coef_slot] = longint'(in_mon.coef_value);
        end else begin
          mix_queue.push_back(vocode(longint'(in_mon.left_in), longint'(in_mon.right_in)));
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got.left  = out_mon.left_out;
        got.right = out_mon.right_out;
        if (mix_queue.size() == 0) begin
          if (fail_count_o < 10)
            $display("unexpected result word: left %h right %h", got.left, got.right);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = mix_queue.pop_front();
          if (want.left !== got.left || want.right !== got.right) begin
            if (fail_count_o < 10)
              $display("mismatch: left exp %h got %h, right exp %h got %h",
                       want.left, got.left, want.right, got.right);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Vocoder testbench top: clock, reset, stimulus on the input and config channels, verdict.
// Depends on svc_pkg, svc_if, the block and svc_checker.
module tb_top;

  localparam int WATCH_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic rdy_q = 1'b0;
  int   send_idle_pct = 21;
  int   recv_idle_pct = 74;
  int   fail_count;
  int   pending;
  int   quiet_cycles = 0;

  svc_in_if  in_ch ();
  svc_out_if out_ch ();
  svc_cfg_if cfg_ch ();

  stereo_channel_vocoder u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  svc_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_mon     (cfg_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: drop ready at random for the current share of cycles.
  assign out_ch.ready = rdy_q;
  always @(posedge clk_i) begin
    rdy_q <= rst_ni && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog: end the run if no word moves on any channel for too long.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCH_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hand one word to the input channel; valid stays high into the next word.
  task automatic push_word(logic op, logic [23:0] l, logic [23:0] r,
                           logic [3:0] band, logic [2:0] slot, logic [23:0] val);
    int gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.left_in    <= l;
    in_ch.right_in   <= r;
    in_ch.coef_band  <= band;
    in_ch.coef_slot  <= slot;
    in_ch.coef_value <= val;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic push_sample(logic [23:0] l, logic [23:0] r);
    push_word(svc_pkg::OP_SAMPLE, l, r, 4'($urandom), 3'($urandom), 24'($urandom));
  endtask

  task automatic push_coef(logic [3:0] band, logic [2:0] slot, logic [23:0] val);
    push_word(svc_pkg::OP_COEF, 24'($urandom), 24'($urandom), band, slot, val);
  endtask

  // Hold off the sender until every result has come, then let the pipeline settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Upper bits beyond the register width are random and must be dropped.
  task automatic write_reg(logic [3:0] idx, logic [23:0] val, int width);
    logic [23:0] noise;
    noise = 24'($urandom);
    if (width < 24) val = (noise << width) | (val & ((24'h1 << width) - 1));
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_mode(logic [4:0] bands, logic [1:0] car, logic [23:0] step,
                          logic [15:0] mix);
    drain();
    write_reg(svc_pkg::CFG_BAND_COUNT, 24'(bands), 5);
    write_reg(svc_pkg::CFG_CARRIER_TYPE, 24'(car), 2);
    write_reg(svc_pkg::CFG_PHASE_STEP, step, 24);
    write_reg(svc_pkg::CFG_MIX_LEVEL, 24'(mix), 16);
  endtask

  // Mostly tame coefficients keep the filters off the rails; some are wild.
  function automatic logic [23:0] pick_coef();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 24'($signed($urandom_range(0, 1048576)) - 524288);
    if (sel < 8) return 24'($urandom);
    return (sel == 8) ? 24'h7FFFFF : 24'h800000;
  endfunction

  function automatic logic [23:0] pick_sample();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return 24'($urandom);
    if (sel == 7) return 24'h7FFFFF;
    if (sel == 8) return 24'h800000;
    return 24'($signed($urandom_range(0, 511)) - 256);
  endfunction

  task automatic load_bank();
    for (int b = 0; b < 16; b++)
      for (int s = 0; s < svc_pkg::NUM_SLOTS; s++)
        push_coef(4'(b), 3'(s), pick_coef());
  endtask

  task automatic random_run(int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 15)
        push_coef(4'($urandom), 3'($urandom_range(0, 7)), pick_coef());
      else
        push_sample(pick_sample(), pick_sample());
    end
  endtask

  logic [4:0]  band_list [8] = '{5'd16, 5'd4, 5'd0, 5'd31, 5'd9, 5'd3, 5'd17, 5'd12};
  logic [1:0]  car_list  [8] = '{svc_pkg::CAR_NOISE, svc_pkg::CAR_SAW, svc_pkg::CAR_SQUARE,
                                 2'd3, svc_pkg::CAR_SAW, svc_pkg::CAR_NOISE,
                                 svc_pkg::CAR_SQUARE, svc_pkg::CAR_SAW};
  logic [23:0] step_list [8] = '{24'd34953, 24'hFFFFFF, 24'd0, 24'd34953, 24'h400000,
                                 24'h000001, 24'h7FFFFF, 24'h123457};
  logic [15:0] mix_list  [8] = '{16'd65535, 16'd0, 16'd32768, 16'd65535, 16'd12000,
                                 16'd1, 16'd50000, 16'd40000};

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.op         = svc_pkg::OP_SAMPLE;
    in_ch.left_in    = '0;
    in_ch.right_in   = '0;
    in_ch.coef_band  = '0;
    in_ch.coef_slot  = '0;
    in_ch.coef_value = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every coefficient is written before any sample reads it.
    load_bank();

    // Directed: sample extremes under reset settings, ignored writes, unknown index.
    push_sample(24'h7FFFFF, 24'h800000);
    push_sample(24'h800000, 24'h7FFFFF);
    push_sample(24'h000000, 24'h000000);
    push_sample(24'h7FFFFF, 24'h7FFFFF);
    push_coef(4'd15, 3'd5, 24'h7FFFFF);
    push_coef(4'd0, 3'd7, 24'h800000);
    push_coef(4'd15, svc_pkg::SLOT_A2, 24'h800000);
    push_sample(24'h800000, 24'h800000);
    set_mode(5'd31, svc_pkg::CAR_SQUARE, 24'hFFFFFF, 16'd65535);
    write_reg(4'd9, 24'hFFFFFF, 24);
    write_reg(4'd15, 24'h000000, 24);
    push_coef(4'd0, svc_pkg::SLOT_B0, 24'h7FFFFF);
    push_sample(24'h7FFFFF, 24'h800000);
    push_sample(24'h800000, 24'h7FFFFF);
    set_mode(5'd0, svc_pkg::CAR_SAW, 24'd0, 16'd0);
    push_sample(24'h7FFFFF, 24'h800000);
    push_sample(24'h123456, 24'hEDCBA9);

    for (int p = 0; p < 8; p++) begin
      set_mode(band_list[p], car_list[p], step_list[p], mix_list[p]);
      if (p == 3) begin
        send_idle_pct = 74;
        recv_idle_pct = 21;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p % 3 == 2) load_bank();
      random_run(120);
    end

    drain();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/svc_pkg.sv
hw/rtl/svc_if.sv
hw/rtl/svc_ram.sv
hw/rtl/stereo_channel_vocoder.sv
sim/svc_checker.sv
sim/tb_top.sv
